// ===== rtl/core/srb_pkg.sv =====
// Shared types and constants of the sequence reorder buffer.
`default_nettype none

package srb_pkg;

   // Default ring size in slots.
   localparam int WINDOW_DEF = 16;

   // A ring slot holds the text flag above the 32-bit handle.
   localparam int SLOT_W = 33;

   // Result kinds.
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_BEYOND   = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] seq_no;
      logic        has_text;
      logic [31:0] text_handle;
      logic [7:0]  sender_id;
      logic        is_direct;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] delivered_text;
      status_type  status;
      logic [7:0]  next_hop;
      logic [31:0] next_expected;
      logic        last;
   } rsp_type;

   // Handoff from the classifier to the result sequencer.
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [7:0]  next_hop;
      logic [31:0] next_expected;
   } tok_type;

endpackage

`default_nettype wire

// ===== rtl/core/srb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module srb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/srb_front.sv =====
// Front part: classifies a request, stores it in the ring and drains in-order slots.
`default_nettype none

module srb_front import srb_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF,
   localparam int IDX_W = $clog2(WINDOW),
   localparam int CNT_W = $clog2(WINDOW + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req_data,
   input  wire logic              route_direct,
   input  wire logic [7:0]        initial_hop,
   // ring memory
   output logic                   slot_we,
   output logic      [IDX_W-1:0]  slot_waddr,
   output logic      [SLOT_W-1:0] slot_wdata,
   output logic                   slot_re,
   output logic      [IDX_W-1:0]  slot_raddr,
   input  wire logic [SLOT_W-1:0] slot_rdata,
   // release queue write side
   output logic                   q_we,
   output logic      [IDX_W-1:0]  q_waddr,
   output logic      [31:0]       q_wdata,
   // handoff to the back part
   output tok_type                tok,
   output logic      [CNT_W-1:0]  tok_cnt
);

   typedef enum logic [2:0] {
      F_IDLE,
      F_CHECK,
      F_STORE,
      F_DRAIN,
      F_REPORT
   } fstate_type;

   fstate_type       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [31:0]      expected_ff, expected_in;
   logic [IDX_W-1:0] exp_slot_ff, exp_slot_in;
   logic [31:0]      newest_ff, newest_in;
   logic [7:0]       hop_ff, hop_in;
   logic             hop_set_ff, hop_set_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic             bad_ff, bad_in;
   logic             far_ff, far_in;
   logic             hit_ff, hit_in;
   logic             newer_ff, newer_in;
   logic             same_ff, same_in;
   logic [IDX_W-1:0] diff_ff, diff_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0] qcnt_ff, qcnt_in;
   status_type       status_ff, status_in;
   tok_type          tok_ff, tok_in;
   logic [CNT_W-1:0] tok_cnt_ff, tok_cnt_in;

   logic [31:0]      diff;
   logic [IDX_W:0]   slot_sum;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] exp_slot_next;

   assign tok     = tok_ff;
   assign tok_cnt = tok_cnt_ff;

   always_comb begin
      diff     = req_ff.seq_no - expected_ff;
      slot_sum = {1'b0, exp_slot_ff} + {1'b0, diff_ff};
      if (slot_sum >= (IDX_W + 1)'(WINDOW)) begin
         slot_sum = slot_sum - (IDX_W + 1)'(WINDOW);
      end
      slot_idx = slot_sum[IDX_W-1:0];

      // The slot of expected_seq follows the counter; when the counter wraps to
      // zero the slot restarts at zero as well.
      if (expected_ff == '1) begin
         exp_slot_next = '0;
      end else if (exp_slot_ff == IDX_W'(WINDOW - 1)) begin
         exp_slot_next = '0;
      end else begin
         exp_slot_next = exp_slot_ff + 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      expected_in = expected_ff;
      exp_slot_in = exp_slot_ff;
      newest_in   = newest_ff;
      hop_in      = hop_ff;
      hop_set_in  = hop_set_ff;
      valid_in    = valid_ff;
      bad_in      = bad_ff;
      far_in      = far_ff;
      hit_in      = hit_ff;
      newer_in    = newer_ff;
      same_in     = same_ff;
      diff_in     = diff_ff;
      rd_pend_in  = 1'b0;
      qcnt_in     = qcnt_ff;
      status_in   = status_ff;
      tok_in      = tok_ff;
      tok_in.valid = 1'b0;
      tok_cnt_in  = tok_cnt_ff;

      slot_we    = 1'b0;
      slot_waddr = slot_idx;
      slot_wdata = {req_ff.has_text, req_ff.text_handle};
      slot_re    = 1'b0;
      slot_raddr = exp_slot_ff;
      q_we       = 1'b0;
      q_waddr    = qcnt_ff[IDX_W-1:0];
      q_wdata    = slot_rdata[31:0];

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               qcnt_in  = '0;
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            bad_in   = (req_ff.seq_no == '0) || (req_ff.seq_no < expected_ff);
            far_in   = diff >= 32'(WINDOW);
            hit_in   = req_ff.seq_no == expected_ff;
            newer_in = req_ff.seq_no > newest_ff;
            same_in  = req_ff.seq_no == newest_ff;
            diff_in  = diff[IDX_W-1:0];
            state_in = F_STORE;
         end
         F_STORE: begin
            state_in = F_REPORT;
            if (bad_ff) begin
               status_in = STATUS_REJECTED;
            end else if (far_ff) begin
               status_in = STATUS_BEYOND;
            end else if (valid_ff[slot_idx]) begin
               status_in = STATUS_REJECTED;
            end else begin
               status_in          = STATUS_ACCEPTED;
               slot_we            = 1'b1;
               valid_in[slot_idx] = 1'b1;
               if (newer_ff || (same_ff && req_ff.is_direct && !route_direct)) begin
                  newest_in  = req_ff.seq_no;
                  hop_in     = req_ff.sender_id;
                  hop_set_in = 1'b1;
               end
               if (hit_ff) begin
                  state_in = F_DRAIN;
               end
            end
         end
         F_DRAIN: begin
            // Read data of the slot released in the previous cycle arrives now.
            if (rd_pend_ff && slot_rdata[SLOT_W-1]) begin
               q_we    = 1'b1;
               qcnt_in = qcnt_ff + 1'b1;
            end
            if (valid_ff[exp_slot_ff]) begin
               slot_re               = 1'b1;
               rd_pend_in            = 1'b1;
               valid_in[exp_slot_ff] = 1'b0;
               expected_in           = expected_ff + 1'b1;
               exp_slot_in           = exp_slot_next;
            end else if (!rd_pend_ff) begin
               state_in = F_REPORT;
            end
         end
         F_REPORT: begin
            tok_in.valid         = 1'b1;
            tok_in.status        = status_ff;
            tok_in.next_hop      = hop_set_ff ? hop_ff : initial_hop;
            tok_in.next_expected = expected_ff;
            tok_cnt_in           = qcnt_ff;
            state_in             = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         expected_ff <= 32'd1;
         exp_slot_ff <= IDX_W'(1 % WINDOW);
         newest_ff   <= '0;
         hop_ff      <= '0;
         hop_set_ff  <= 1'b0;
         valid_ff    <= '0;
         rd_pend_ff  <= 1'b0;
         qcnt_ff     <= '0;
         tok_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         exp_slot_ff <= exp_slot_in;
         newest_ff   <= newest_in;
         hop_ff      <= hop_in;
         hop_set_ff  <= hop_set_in;
         valid_ff    <= valid_in;
         rd_pend_ff  <= rd_pend_in;
         qcnt_ff     <= qcnt_in;
         tok_ff      <= tok_in;
      end
      req_ff     <= req_in;
      bad_ff     <= bad_in;
      far_ff     <= far_in;
      hit_ff     <= hit_in;
      newer_ff   <= newer_in;
      same_ff    <= same_in;
      diff_ff    <= diff_in;
      status_ff  <= status_in;
      tok_cnt_ff <= tok_cnt_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/srb_back.sv =====
// Back part: reads released text handles from the queue and issues the results.
`default_nettype none

module srb_back import srb_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF,
   localparam int IDX_W = $clog2(WINDOW),
   localparam int CNT_W = $clog2(WINDOW + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tok_type          tok,
   input  wire logic [CNT_W-1:0] tok_cnt,
   output logic                  q_re,
   output logic      [IDX_W-1:0] q_raddr,
   input  wire logic [31:0]      q_rdata,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   typedef enum logic {
      B_IDLE,
      B_RUN
   } bstate_type;

   bstate_type       state_ff, state_in;
   tok_type          tok_ff, tok_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [IDX_W-1:0] rptr_ff, rptr_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      tok_in       = tok_ff;
      remain_in    = remain_ff;
      rptr_in      = rptr_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_re         = 1'b0;
      q_raddr      = rptr_ff;

      case (state_ff)
         B_IDLE: begin
            if (tok.valid) begin
               tok_in    = tok;
               remain_in = tok_cnt;
               rptr_in   = '0;
               state_in  = B_RUN;
            end
         end
         B_RUN: begin
            if (pend_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_DELIVER;
               rsp_in.delivered_text = q_rdata;
               rsp_in.status         = STATUS_ACCEPTED;
               rsp_in.next_hop       = tok_ff.next_hop;
               rsp_in.next_expected  = tok_ff.next_expected;
               rsp_in.last           = 1'b0;
            end
            if (remain_ff != '0) begin
               q_re      = 1'b1;
               pend_in   = 1'b1;
               rptr_in   = rptr_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
            end else if (!pend_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_STATUS;
               rsp_in.delivered_text = '0;
               rsp_in.status         = tok_ff.status;
               rsp_in.next_hop       = tok_ff.next_hop;
               rsp_in.next_expected  = tok_ff.next_expected;
               rsp_in.last           = 1'b1;
               state_in              = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
      tok_ff  <= tok_in;
      rptr_ff <= rptr_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/sequence_reorder_buffer_unit.sv =====
// Top level of the sequence reorder buffer: register port, front, queue and back.
// A rejected or non-draining request shows only its status; one that drains n slots
// (one per cycle) and delivers d texts shows its d deliveries, then its status result.
// One request is taken at a time; busy falls right after the status result, and the
// receiver cannot stall. Reset is synchronous, active high.
`default_nettype none

module sequence_reorder_buffer_unit import srb_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   // result channel
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   // Register select is address bit 2: route_direct at 0, initial_hop at 4.
   localparam logic REG_ROUTE_DIRECT = 1'b0;
   localparam logic REG_INITIAL_HOP  = 1'b1;

   logic        busy_ff, busy_in;
   logic        route_direct_ff, route_direct_in;
   logic [7:0]  initial_hop_ff, initial_hop_in;
   logic        accept;
   logic        cfg_write;

   logic              slot_we;
   logic [IDX_W-1:0]  slot_waddr;
   logic [SLOT_W-1:0] slot_wdata;
   logic              slot_re;
   logic [IDX_W-1:0]  slot_raddr;
   logic [SLOT_W-1:0] slot_rdata;

   logic              q_we;
   logic [IDX_W-1:0]  q_waddr;
   logic [31:0]       q_wdata;
   logic              q_re;
   logic [IDX_W-1:0]  q_raddr;
   logic [31:0]       q_rdata;

   tok_type           tok;
   logic [CNT_W-1:0]  tok_cnt;

   // A request is taken whenever the unit is not busy; it stays busy until the
   // status result of that request has been shown.
   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_valid && rsp_data.last) begin
         busy_in = 1'b0;
      end
   end

   // Register port: writes land on the access phase; reads are returned at once.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      route_direct_in = route_direct_ff;
      initial_hop_in  = initial_hop_ff;
      if (cfg_write) begin
         case (paddr[2])
            REG_ROUTE_DIRECT: route_direct_in = pwdata[0];
            REG_INITIAL_HOP:  initial_hop_in  = pwdata[7:0];
            default: begin
               route_direct_in = route_direct_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ROUTE_DIRECT: prdata = {31'd0, route_direct_ff};
         REG_INITIAL_HOP:  prdata = {24'd0, initial_hop_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         route_direct_ff <= 1'b0;
         initial_hop_ff  <= '0;
      end else begin
         busy_ff         <= busy_in;
         route_direct_ff <= route_direct_in;
         initial_hop_ff  <= initial_hop_in;
      end
   end

   // Front: classifies the request, updates the ring and the route, and drains
   // consecutive slots starting at the expected number.
   srb_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .route_direct (route_direct_ff),
      .initial_hop  (initial_hop_ff),
      .slot_we      (slot_we),
      .slot_waddr   (slot_waddr),
      .slot_wdata   (slot_wdata),
      .slot_re      (slot_re),
      .slot_raddr   (slot_raddr),
      .slot_rdata   (slot_rdata),
      .q_we         (q_we),
      .q_waddr      (q_waddr),
      .q_wdata      (q_wdata),
      .tok          (tok),
      .tok_cnt      (tok_cnt)
   );

   // Ring of held messages: text flag and handle per slot.
   srb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // Queue of released text handles between the front and the back.
   srb_ram #(
      .WIDTH (32),
      .DEPTH (WINDOW)
   ) u_release_q (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .re    (q_re),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   // Back: plays out the deliveries and then the status result.
   srb_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .tok_cnt   (tok_cnt),
      .q_re      (q_re),
      .q_raddr   (q_raddr),
      .q_rdata   (q_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/srb_checker.sv =====
// Port-level checker of the sequence reorder buffer, bound to the top level.
`default_nettype none

module srb_checker import srb_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // Results only appear while a request is in flight.
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while not busy");

   // An accepted request keeps the unit busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request");

   // Only the status result closes a run, and it never carries delivery data.
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == rsp_data.kind))
      else $error("last flag and result kind disagree");

   // Deliveries and the closing status come in one unbroken burst.
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> rsp_valid)
      else $error("gap inside a result burst");

   // Nothing follows the status result of a run.
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> (!rsp_valid && !busy))
      else $error("activity after the status result");

endmodule

bind sequence_reorder_buffer_unit srb_checker u_srb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the sequence reorder buffer: directed and random messages.
`timescale 1ns / 1ps

module testbench;
   import srb_pkg::*;

   localparam int RING_SLOTS = WINDOW_DEF;

   // Register indexes of the configuration port.
   localparam int REG_ROUTE_DIRECT = 0;
   localparam int REG_INITIAL_HOP  = 1;

   // With no handshake for this many cycles the run is declared hung. The longest quiet
   // stretch of a correct run is a full 16-slot drain before its first result.
   localparam int STALL_LIMIT = 2000;

   // Cycles to linger after the last result so that a stray extra result is caught.
   localparam int TAIL_CYCLES = 60;

   // Kinds of out-of-order noise mixed into the well-formed random traffic.
   typedef enum int {
      NOISE_ZERO,
      NOISE_STALE,
      NOISE_REPEAT,
      NOISE_BEYOND,
      NOISE_TOP,
      NOISE_WILD
   } noise_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sequence_reorder_buffer_unit #(
      .WINDOW(RING_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Messages waiting to be sent, and the deliveries and statuses they must produce.
   req_type message_queue[$];
   rsp_type release_queue[$];

   // Our own copy of the ring and the route state.
   logic        ring_valid [RING_SLOTS];
   logic        ring_text  [RING_SLOTS];
   logic [31:0] ring_handle[RING_SLOTS];
   logic [31:0] model_expected = 32'd1;
   logic [31:0] model_newest = '0;
   logic [7:0]  model_hop = '0;
   logic        model_hop_set = 1'b0;
   logic        cfg_route_direct = 1'b0;
   logic [7:0]  cfg_initial_hop = '0;

   int  mismatch_count = 0;
   int  accepted_messages = 0;
   int  delivered_seen = 0;
   int  rejected_seen = 0;
   int  beyond_seen = 0;
   int  stall_cycles = 0;
   int  idle_left = 0;
   int  gen_next = 1;
   bit  steady_phase = 1'b0;

   // Works out what one accepted message releases. All state changes happen first,
   // because every result of the message reports the route and the expected number
   // as they stand once the message has been handled.
   task automatic reorder_message(input req_type msg);
      logic [31:0] released[$];
      logic [31:0] ahead;
      status_type  verdict;
      int unsigned slot;
      rsp_type     outcome;
      ahead = msg.seq_no - model_expected;
      if (msg.seq_no == 32'd0 || msg.seq_no < model_expected) begin
         verdict = STATUS_REJECTED;
      end else if (ahead >= RING_SLOTS) begin
         verdict = STATUS_BEYOND;
      end else if (ring_valid[msg.seq_no % RING_SLOTS]) begin
         verdict = STATUS_REJECTED;
      end else begin
         verdict = STATUS_ACCEPTED;
         slot = msg.seq_no % RING_SLOTS;
         ring_valid[slot] = 1'b1;
         ring_text[slot] = msg.has_text;
         ring_handle[slot] = msg.text_handle;
         // Only the in-order number starts a drain; it walks as far as the held run goes.
         if (msg.seq_no == model_expected) begin
            while (ring_valid[model_expected % RING_SLOTS]) begin
               slot = model_expected % RING_SLOTS;
               if (ring_text[slot]) begin
                  released.push_back(ring_handle[slot]);
               end
               ring_valid[slot] = 1'b0;
               ring_text[slot] = 1'b0;
               ring_handle[slot] = '0;
               model_expected = model_expected + 32'd1;
            end
         end
         // The newest number takes over the route; an equal number may only do so
         // when it comes direct and the route_direct setting is clear.
         if (msg.seq_no > model_newest ||
             (msg.seq_no == model_newest && msg.is_direct && !cfg_route_direct)) begin
            model_newest = msg.seq_no;
            model_hop = msg.sender_id;
            model_hop_set = 1'b1;
         end
      end
      outcome.next_hop = model_hop_set ? model_hop : cfg_initial_hop;
      outcome.next_expected = model_expected;
      foreach (released[k]) begin
         outcome.kind = KIND_DELIVER;
         outcome.delivered_text = released[k];
         outcome.status = STATUS_ACCEPTED;
         outcome.last = 1'b0;
         release_queue.push_back(outcome);
      end
      outcome.kind = KIND_STATUS;
      outcome.delivered_text = '0;
      outcome.status = verdict;
      outcome.last = 1'b1;
      release_queue.push_back(outcome);
   endtask

   task automatic queue_message(input logic [31:0] seq_no, input logic has_text,
                                input logic [31:0] text_handle, input logic [7:0] sender_id,
                                input logic is_direct);
      req_type msg;
      msg.seq_no = seq_no;
      msg.has_text = has_text;
      msg.text_handle = text_handle;
      msg.sender_id = sender_id;
      msg.is_direct = is_direct;
      message_queue.push_back(msg);
   endtask

   // Random traffic is built from windows of fresh numbers sent in shuffled order, so
   // that most messages are held and later drained. Now and then a zero, stale,
   // repeated, far-off or random number is slipped in between.
   task automatic queue_random_traffic(input int target);
      int unsigned order[RING_SLOTS];
      int          queued;
      int          span;
      int          pick;
      int unsigned swap;
      logic [31:0] seq_no;
      noise_type   noise;
      queued = 0;
      while (queued < target) begin
         span = ($urandom_range(0, 6) == 0) ? RING_SLOTS : $urandom_range(1, 6);
         for (int k = 0; k < span; k++) begin
            order[k] = gen_next + k;
         end
         for (int k = span - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            swap = order[k];
            order[k] = order[pick];
            order[pick] = swap;
         end
         for (int k = 0; k < span; k++) begin
            queue_message(order[k], $urandom_range(0, 3) != 0, $urandom,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            queued++;
            if ($urandom_range(0, 5) == 0) begin
               noise = noise_type'($urandom_range(NOISE_ZERO, NOISE_WILD));
               case (noise)
                  NOISE_ZERO:   seq_no = '0;
                  NOISE_STALE:  seq_no = gen_next - $urandom_range(1, gen_next - 1);
                  NOISE_REPEAT: seq_no = order[$urandom_range(0, k)];
                  NOISE_BEYOND: seq_no = gen_next + span + RING_SLOTS + $urandom_range(0, 999);
                  NOISE_TOP:    seq_no = 32'hFFFF_FFFF - $urandom_range(0, 3);
                  default:      seq_no = $urandom;
               endcase
               queue_message(seq_no, 1'($urandom_range(0, 1)), $urandom,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               queued++;
            end
         end
         gen_next = gen_next + span;
      end
   endtask

   task automatic write_register(input int index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(index * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == REG_ROUTE_DIRECT) begin
         cfg_route_direct = value[0];
      end else if (index == REG_INITIAL_HOP) begin
         cfg_initial_hop = value[7:0];
      end
   endtask

   // Sampled on the falling edge so that every update of the rising edge has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (message_queue.size() != 0 || start || busy || release_queue.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver. A request is taken at an edge where start is high and busy is
   // low; after that the next queued message is offered at once or after a short gap.
   always @(posedge clock) begin
      logic start_next;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         start_next = start;
         if (start && !busy) begin
            reorder_message(req_data);
            accepted_messages++;
            start_next = 1'b0;
            if (!steady_phase && $urandom_range(0, 2) == 0) begin
               idle_left = $urandom_range(1, 12);
            end
         end
         if (!start_next) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (message_queue.size() > 0) begin
               req_data <= message_queue.pop_front();
               start_next = 1'b1;
            end
         end
         start <= start_next;
      end
   end

   // Result monitor. Results cannot be held off, so each strobe is compared at once
   // against the oldest outstanding expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (release_queue.size() == 0) begin
            $error("result with nothing outstanding: kind %0d, status %0d",
                   rsp_data.kind, rsp_data.status);
            mismatch_count++;
         end else begin
            want = release_queue.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            compare_field("delivered_text", want.delivered_text, rsp_data.delivered_text);
            compare_field("status", 32'(want.status), 32'(rsp_data.status));
            compare_field("next_hop", 32'(want.next_hop), 32'(rsp_data.next_hop));
            compare_field("next_expected", want.next_expected, rsp_data.next_expected);
            compare_field("last", 32'(want.last), 32'(rsp_data.last));
            if (want.kind == KIND_DELIVER) begin
               delivered_seen++;
            end else if (want.status == STATUS_REJECTED) begin
               rejected_seen++;
            end else if (want.status == STATUS_BEYOND) begin
               beyond_seen++;
            end
         end
      end
   end

   // Watchdog: any request, result or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                  stall_cycles, release_queue.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      foreach (ring_valid[k]) begin
         ring_valid[k] = 1'b0;
         ring_text[k] = 1'b0;
         ring_handle[k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The initial hop is visible until the first message is accepted.
      write_register(REG_ROUTE_DIRECT, 32'd0);
      write_register(REG_INITIAL_HOP, 32'd255);
      @(negedge clock);
      queue_message(32'd0, 1'b1, 32'h0000_0000, 8'h00, 1'b0);       // number zero
      queue_message(32'd1, 1'b1, 32'hFFFF_FFFF, 8'h3C, 1'b1);       // in order, delivered
      queue_message(32'd1, 1'b1, 32'h1234_5678, 8'hFF, 1'b1);       // stale
      queue_message(32'd3, 1'b1, 32'h0000_0000, 8'h00, 1'b0);       // held
      queue_message(32'd4, 1'b0, 32'hDEAD_BEEF, 8'h81, 1'b0);       // held route rumor
      queue_message(32'd2, 1'b1, 32'hA5A5_5A5A, 8'h7E, 1'b1);       // drains 2 to 4
      queue_message(32'd21, 1'b1, 32'h0000_0021, 8'h21, 1'b1);      // just past the window
      queue_message(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      queue_message(32'd20, 1'b1, 32'h0000_0020, 8'hFF, 1'b0);      // top of the window
      queue_message(32'd20, 1'b1, 32'h0000_0BAD, 8'h11, 1'b1);      // duplicate, direct
      for (int k = 6; k <= 19; k++) begin
         queue_message(k, k % 3 != 0, 32'hC0DE_0000 + k, 8'(k), 1'(k % 2));
      end
      queue_message(32'd5, 1'b1, 32'h5555_AAAA, 8'h00, 1'b0);       // drains a full ring
      gen_next = 21;
      wait_drained();

      // Random phases. Each waits for the ring to go quiet before the next setting,
      // and the last one sends back to back with no gaps.
      write_register(REG_ROUTE_DIRECT, 32'd1);
      write_register(REG_INITIAL_HOP, 32'd0);
      @(negedge clock);
      queue_random_traffic(112);
      wait_drained();

      write_register(REG_ROUTE_DIRECT, 32'd0);
      write_register(REG_INITIAL_HOP, 32'h5A);
      @(negedge clock);
      queue_random_traffic(112);
      wait_drained();

      write_register(REG_ROUTE_DIRECT, 32'd1);
      write_register(REG_INITIAL_HOP, 32'hFF);
      @(negedge clock);
      steady_phase = 1'b1;
      queue_random_traffic(112);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d messages in four register settings, up to full-ring drains.",
               accepted_messages);
      $display("Results: %0d texts delivered, %0d rejected, %0d beyond the window.",
               delivered_seen, rejected_seen, beyond_seen);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/srb_pkg.sv
rtl/core/srb_ram.sv
rtl/core/srb_front.sv
rtl/core/srb_back.sv
rtl/core/sequence_reorder_buffer_unit.sv
rtl/core/srb_checker.sv
dv/testbench.sv
